### rtl/code39_edge_timing_decoder_defines.svh
// Assertion macros shared by the decoder RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef CODE39_EDGE_TIMING_DECODER_DEFINES_SVH
`define CODE39_EDGE_TIMING_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define C39_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define C39_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/c39etd_pkg.sv
`timescale 1ns / 1ps

package c39etd_pkg;

    localparam int EDGE_W    = 32;
    localparam int TIMEOUT_W = 16;
    localparam int CHAR_W    = 7;
    localparam int WIN_LEN   = 10;
    localparam int NUM_ELEM  = 9;
    localparam int IDX_W     = 4;
    localparam int NUM_WIDE  = 3;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1200;

    localparam logic [IDX_W-1:0] FILL_LAST = IDX_W'(WIN_LEN - 1);
    localparam logic [IDX_W-1:0] FILL_FULL = IDX_W'(WIN_LEN);
    localparam logic [IDX_W-1:0] CNT_LAST  = IDX_W'(NUM_ELEM);

    // Patterns are written with the first element in the leftmost bit.
    localparam logic [NUM_ELEM-1:0] STAR_FWD = 9'b010010100;
    localparam logic [NUM_ELEM-1:0] STAR_REV = 9'b001010010;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_END     = 2'd1,
        KIND_CANCEL  = 2'd2,
        KIND_INVALID = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WIDTH,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic rotate;
    } win_ctl_t;

    typedef struct packed {
        logic             clear;
        logic             insert;
        logic [IDX_W-1:0] idx;
    } rank_ctl_t;

    function automatic logic [NUM_ELEM-1:0] reverse_pattern(input logic [NUM_ELEM-1:0] pat);
        logic [NUM_ELEM-1:0] r;
        for (int i = 0; i < NUM_ELEM; i++)
        begin
            r[i] = pat[NUM_ELEM-1-i];
        end
        return r;
    endfunction

    // Returns {hit, ascii}. A miss returns all zeros.
    function automatic logic [CHAR_W:0] lookup_char(input logic [NUM_ELEM-1:0] pat);
        logic [CHAR_W:0] r;
        case (pat)
            9'b011000100: r = {1'b1, 7'h20};
            9'b100001001: r = {1'b1, 7'h41};
            9'b001001001: r = {1'b1, 7'h42};
            9'b101001000: r = {1'b1, 7'h43};
            9'b000011001: r = {1'b1, 7'h44};
            9'b100011000: r = {1'b1, 7'h45};
            9'b001011000: r = {1'b1, 7'h46};
            9'b000001101: r = {1'b1, 7'h47};
            9'b100001100: r = {1'b1, 7'h48};
            9'b001001100: r = {1'b1, 7'h49};
            9'b000011100: r = {1'b1, 7'h4A};
            9'b100000011: r = {1'b1, 7'h4B};
            9'b001000011: r = {1'b1, 7'h4C};
            9'b101000010: r = {1'b1, 7'h4D};
            9'b000010011: r = {1'b1, 7'h4E};
            9'b100010010: r = {1'b1, 7'h4F};
            9'b001010010: r = {1'b1, 7'h50};
            9'b000000111: r = {1'b1, 7'h51};
            9'b100000110: r = {1'b1, 7'h52};
            9'b001000110: r = {1'b1, 7'h53};
            9'b000010110: r = {1'b1, 7'h54};
            9'b110000001: r = {1'b1, 7'h55};
            9'b011000001: r = {1'b1, 7'h56};
            9'b111000000: r = {1'b1, 7'h57};
            9'b010010001: r = {1'b1, 7'h58};
            9'b110010000: r = {1'b1, 7'h59};
            9'b011010000: r = {1'b1, 7'h5A};
            9'b010000101: r = {1'b1, 7'h2D};
            9'b110000100: r = {1'b1, 7'h2E};
            9'b010101000: r = {1'b1, 7'h24};
            9'b010100010: r = {1'b1, 7'h2F};
            9'b010001010: r = {1'b1, 7'h2B};
            9'b000101010: r = {1'b1, 7'h25};
            9'b000110100: r = {1'b1, 7'h30};
            9'b100100001: r = {1'b1, 7'h31};
            9'b001100001: r = {1'b1, 7'h32};
            9'b101100000: r = {1'b1, 7'h33};
            9'b000110001: r = {1'b1, 7'h34};
            9'b100110000: r = {1'b1, 7'h35};
            9'b001110000: r = {1'b1, 7'h36};
            9'b000100101: r = {1'b1, 7'h37};
            9'b100100100: r = {1'b1, 7'h38};
            9'b001100100: r = {1'b1, 7'h39};
            default:      r = '0;
        endcase
        return r;
    endfunction

endpackage

### rtl/code39_edge_timing_decoder.sv
`timescale 1ns / 1ps

// Code 39 decoder working on edge timestamps. Each input item is the millisecond
// time of one bar/space transition. The first nine items of a window are taken
// in one cycle each. The item that completes a window of ten starts a walk
// through a single subtract-and-compare unit, which forms the nine element
// widths and checks each against timeout_ms, while a three-slot sorter keeps
// the three widest elements. The pattern is then matched in a decide step and,
// when there is a result, it is loaded into the output register. A completing
// item holds the input until the walk, the decision and any load are done; a
// width over the limit cuts the walk short and goes to loading the cancel. A
// load waits while an earlier result still sits unread in the output register.
// Results are:
// a data character (kind 0), end of string (kind 1), timeout cancel (kind 2) and
// invalid pattern (kind 3); char_code is zero for everything but kind 0. A
// timeout or the closing star returns the scan to its reset state. timeout_ms
// resets to 1200 and may be written any time the block is idle.
module code39_edge_timing_decoder
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input stream. tdata: edge_time[31:0].
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [c39etd_pkg::EDGE_W-1:0]        s_tdata,
    // Result stream. tdata: char_code[6:0], zero pad[7]. tuser: result_kind[1:0].
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [7:0]                           m_tdata,
    output logic [1:0]                           m_tuser,
    // Timeout register write port.
    input  logic                                 cfg_wr_en,
    input  logic [c39etd_pkg::TIMEOUT_W-1:0]     cfg_wr_data
);

    logic [c39etd_pkg::TIMEOUT_W-1:0] timeout_ms_reg, timeout_ms_next;
    c39etd_pkg::win_ctl_t  win_ctl;
    c39etd_pkg::rank_ctl_t rank_ctl;
    logic [c39etd_pkg::EDGE_W-1:0]   width;
    logic                            over;
    logic [c39etd_pkg::NUM_ELEM-1:0] pattern;
    logic [c39etd_pkg::CHAR_W-1:0]   m_char;
    c39etd_pkg::kind_t               m_kind;

    // The timeout register keeps its value across scan cancels.
    assign timeout_ms_next = cfg_wr_en ? cfg_wr_data : timeout_ms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ms_reg <= c39etd_pkg::TIMEOUT_RESET;
        end
        else
        begin
            timeout_ms_reg <= timeout_ms_next;
        end
    end

    // Edge line and the shared width unit.
    c39etd_window u_window
    (
        .clk        (clk),
        .win_ctl    (win_ctl),
        .edge_time  (s_tdata),
        .timeout_ms (timeout_ms_reg),
        .width      (width),
        .over       (over)
    );

    // Picks the three wide elements as widths stream out of the unit.
    c39etd_rank u_rank
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rank_ctl (rank_ctl),
        .width    (width),
        .pattern  (pattern)
    );

    // Sequencer, scan state and output register.
    c39etd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .pattern  (pattern),
        .over     (over),
        .win_ctl  (win_ctl),
        .rank_ctl (rank_ctl),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_char   (m_char),
        .m_kind   (m_kind)
    );

    assign m_tdata = {1'b0, m_char};
    assign m_tuser = m_kind;

endmodule

### rtl/c39etd_window.sv
`timescale 1ns / 1ps

// Ten-tap edge line with the shared subtract and timeout compare unit.
// Rotating the line walks every neighboring pair past taps 0 and 1.
module c39etd_window
(
    input  logic                                 clk,
    input  c39etd_pkg::win_ctl_t                 win_ctl,
    input  logic [c39etd_pkg::EDGE_W-1:0]        edge_time,
    input  logic [c39etd_pkg::TIMEOUT_W-1:0]     timeout_ms,
    output logic [c39etd_pkg::EDGE_W-1:0]        width,
    output logic                                 over
);

    logic [c39etd_pkg::EDGE_W-1:0] taps_reg  [c39etd_pkg::WIN_LEN];
    logic [c39etd_pkg::EDGE_W-1:0] taps_next [c39etd_pkg::WIN_LEN];

    always_comb
    begin
        for (int k = 0; k < c39etd_pkg::WIN_LEN; k++)
        begin
            taps_next[k] = taps_reg[k];
        end
        if (win_ctl.load)
        begin
            for (int k = 0; k < c39etd_pkg::WIN_LEN - 1; k++)
            begin
                taps_next[k] = taps_reg[k+1];
            end
            taps_next[c39etd_pkg::WIN_LEN-1] = edge_time;
        end
        else if (win_ctl.rotate)
        begin
            for (int k = 0; k < c39etd_pkg::WIN_LEN - 1; k++)
            begin
                taps_next[k] = taps_reg[k+1];
            end
            taps_next[c39etd_pkg::WIN_LEN-1] = taps_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        taps_reg <= taps_next;
    end

    // Widths wrap modulo 2^32, as the timestamps do.
    assign width = taps_reg[1] - taps_reg[0];
    assign over  = width > c39etd_pkg::EDGE_W'(timeout_ms);

endmodule

### rtl/c39etd_rank.sv
`timescale 1ns / 1ps

// Keeps the three widest elements seen so far, ordered by width, then by index.
// A newcomer passes a held element only when strictly wider.
module c39etd_rank
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  c39etd_pkg::rank_ctl_t                rank_ctl,
    input  logic [c39etd_pkg::EDGE_W-1:0]        width,
    output logic [c39etd_pkg::NUM_ELEM-1:0]      pattern
);

    logic [c39etd_pkg::EDGE_W-1:0] val_reg  [c39etd_pkg::NUM_WIDE];
    logic [c39etd_pkg::EDGE_W-1:0] val_next [c39etd_pkg::NUM_WIDE];
    logic [c39etd_pkg::IDX_W-1:0]  idx_reg  [c39etd_pkg::NUM_WIDE];
    logic [c39etd_pkg::IDX_W-1:0]  idx_next [c39etd_pkg::NUM_WIDE];
    logic [c39etd_pkg::NUM_WIDE-1:0] vld_reg;
    logic [c39etd_pkg::NUM_WIDE-1:0] vld_next;
    logic [c39etd_pkg::NUM_WIDE-1:0] beats;

    always_comb
    begin
        for (int s = 0; s < c39etd_pkg::NUM_WIDE; s++)
        begin
            beats[s] = !vld_reg[s] || (width > val_reg[s]);
        end
    end

    always_comb
    begin
        val_next = val_reg;
        idx_next = idx_reg;
        vld_next = vld_reg;
        if (rank_ctl.clear)
        begin
            vld_next = '0;
        end
        else if (rank_ctl.insert)
        begin
            if (beats[0])
            begin
                val_next[2] = val_reg[1];
                idx_next[2] = idx_reg[1];
                val_next[1] = val_reg[0];
                idx_next[1] = idx_reg[0];
                val_next[0] = width;
                idx_next[0] = rank_ctl.idx;
                vld_next    = {vld_reg[1], vld_reg[0], 1'b1};
            end
            else if (beats[1])
            begin
                val_next[2] = val_reg[1];
                idx_next[2] = idx_reg[1];
                val_next[1] = width;
                idx_next[1] = rank_ctl.idx;
                vld_next    = {vld_reg[1], 1'b1, vld_reg[0]};
            end
            else if (beats[2])
            begin
                val_next[2] = width;
                idx_next[2] = rank_ctl.idx;
                vld_next[2] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        idx_reg <= idx_next;
    end

    // First element lands in the leftmost pattern bit.
    always_comb
    begin
        for (int i = 0; i < c39etd_pkg::NUM_ELEM; i++)
        begin
            pattern[c39etd_pkg::NUM_ELEM-1-i] = 1'b0;
            for (int s = 0; s < c39etd_pkg::NUM_WIDE; s++)
            begin
                if (vld_reg[s] && idx_reg[s] == c39etd_pkg::IDX_W'(i))
                begin
                    pattern[c39etd_pkg::NUM_ELEM-1-i] = 1'b1;
                end
            end
        end
    end

endmodule

### rtl/c39etd_ctrl.sv
`timescale 1ns / 1ps
`include "code39_edge_timing_decoder_defines.svh"

// Sequencer: window fill, the width walk, symbol decision and the output register.
module c39etd_ctrl
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [c39etd_pkg::NUM_ELEM-1:0]      pattern,
    input  logic                                 over,
    output c39etd_pkg::win_ctl_t                 win_ctl,
    output c39etd_pkg::rank_ctl_t                rank_ctl,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [c39etd_pkg::CHAR_W-1:0]        m_char,
    output c39etd_pkg::kind_t                    m_kind
);

    c39etd_pkg::state_t state_reg, state_next;
    logic [c39etd_pkg::IDX_W-1:0] fill_reg, fill_next;
    logic [c39etd_pkg::IDX_W-1:0] cnt_reg, cnt_next;
    logic synced_reg, synced_next;
    logic reversed_reg, reversed_next;
    logic stars_seen_reg, stars_seen_next;
    logic last_star_reg, last_star_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [c39etd_pkg::CHAR_W-1:0] m_char_reg, m_char_next;
    c39etd_pkg::kind_t m_kind_reg, m_kind_next;
    logic [c39etd_pkg::CHAR_W-1:0] res_char_reg, res_char_next;
    c39etd_pkg::kind_t res_kind_reg, res_kind_next;

    logic in_acc;
    logic out_free;
    logic is_star;
    logic decide_emit;
    logic [c39etd_pkg::NUM_ELEM-1:0] lookup_pat;
    logic [c39etd_pkg::CHAR_W:0] lut;

    assign s_tready = (state_reg == c39etd_pkg::ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign is_star     = pattern inside {c39etd_pkg::STAR_FWD, c39etd_pkg::STAR_REV};
    assign decide_emit = is_star ? (!last_star_reg && stars_seen_reg) : synced_reg;
    assign lookup_pat  = reversed_reg ? c39etd_pkg::reverse_pattern(pattern) : pattern;
    assign lut         = c39etd_pkg::lookup_char(lookup_pat);

    always_comb
    begin : next_state
        state_next = state_reg;
        case (state_reg)
            c39etd_pkg::ST_IDLE:
            begin
                if (in_acc && fill_reg == c39etd_pkg::FILL_LAST)
                begin
                    state_next = c39etd_pkg::ST_WIDTH;
                end
            end
            c39etd_pkg::ST_WIDTH:
            begin
                if (cnt_reg == c39etd_pkg::CNT_LAST)
                begin
                    state_next = c39etd_pkg::ST_DECIDE;
                end
                else if (over)
                begin
                    state_next = c39etd_pkg::ST_EMIT;
                end
            end
            c39etd_pkg::ST_DECIDE:
            begin
                state_next = decide_emit ? c39etd_pkg::ST_EMIT : c39etd_pkg::ST_IDLE;
            end
            c39etd_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = c39etd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = c39etd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin : outputs
        win_ctl         = '0;
        rank_ctl        = '0;
        rank_ctl.idx    = cnt_reg;
        fill_next       = fill_reg;
        cnt_next        = cnt_reg;
        synced_next     = synced_reg;
        reversed_next   = reversed_reg;
        stars_seen_next = stars_seen_reg;
        last_star_next  = last_star_reg;
        res_char_next   = res_char_reg;
        res_kind_next   = res_kind_reg;
        m_char_next     = m_char_reg;
        m_kind_next     = m_kind_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        case (state_reg)
            c39etd_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    win_ctl.load = 1'b1;
                    fill_next    = fill_reg + c39etd_pkg::IDX_W'(1);
                    if (fill_reg == c39etd_pkg::FILL_LAST)
                    begin
                        rank_ctl.clear = 1'b1;
                        cnt_next       = '0;
                    end
                end
            end
            c39etd_pkg::ST_WIDTH:
            begin
                // The tenth rotation only brings the line back to its order.
                win_ctl.rotate = 1'b1;
                cnt_next       = cnt_reg + c39etd_pkg::IDX_W'(1);
                if (cnt_reg != c39etd_pkg::CNT_LAST)
                begin
                    rank_ctl.insert = 1'b1;
                    if (over)
                    begin
                        fill_next       = '0;
                        synced_next     = 1'b0;
                        reversed_next   = 1'b0;
                        stars_seen_next = 1'b0;
                        last_star_next  = 1'b0;
                        res_char_next   = '0;
                        res_kind_next   = c39etd_pkg::KIND_CANCEL;
                    end
                end
            end
            c39etd_pkg::ST_DECIDE:
            begin
                if (is_star)
                begin
                    fill_next   = '0;
                    synced_next = 1'b1;
                    if (pattern == c39etd_pkg::STAR_REV)
                    begin
                        reversed_next = 1'b1;
                    end
                    if (!last_star_reg)
                    begin
                        if (stars_seen_reg)
                        begin
                            // Closing star ends the string and clears the scan.
                            synced_next     = 1'b0;
                            reversed_next   = 1'b0;
                            stars_seen_next = 1'b0;
                            last_star_next  = 1'b0;
                            res_char_next   = '0;
                            res_kind_next   = c39etd_pkg::KIND_END;
                        end
                        else
                        begin
                            stars_seen_next = 1'b1;
                            last_star_next  = 1'b1;
                        end
                    end
                end
                else if (!synced_reg)
                begin
                    // Slide: the oldest edge drops out on the next load.
                    fill_next = c39etd_pkg::FILL_LAST;
                end
                else
                begin
                    fill_next      = '0;
                    last_star_next = 1'b0;
                    if (lut[c39etd_pkg::CHAR_W])
                    begin
                        res_char_next = lut[c39etd_pkg::CHAR_W-1:0];
                        res_kind_next = c39etd_pkg::KIND_DATA;
                    end
                    else
                    begin
                        res_char_next = '0;
                        res_kind_next = c39etd_pkg::KIND_INVALID;
                    end
                end
            end
            c39etd_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_char_next   = res_char_reg;
                    m_kind_next   = res_kind_reg;
                end
            end
            default:
            begin
                fill_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= c39etd_pkg::ST_IDLE;
            fill_reg       <= '0;
            cnt_reg        <= '0;
            synced_reg     <= 1'b0;
            reversed_reg   <= 1'b0;
            stars_seen_reg <= 1'b0;
            last_star_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            cnt_reg        <= cnt_next;
            synced_reg     <= synced_next;
            reversed_reg   <= reversed_next;
            stars_seen_reg <= stars_seen_next;
            last_star_reg  <= last_star_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_char_reg   <= m_char_next;
        m_kind_reg   <= m_kind_next;
        res_char_reg <= res_char_next;
        res_kind_reg <= res_kind_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_char   = m_char_reg;
    assign m_kind   = m_kind_reg;

    `C39_ASSERT_SAME(a_full_at_decide, state_reg == c39etd_pkg::ST_DECIDE, fill_reg == c39etd_pkg::FILL_FULL, "decision taken on a window that is not full")
    `C39_ASSERT_NEXT(a_tenth_edge_walks, in_acc && fill_reg == c39etd_pkg::FILL_LAST, state_reg == c39etd_pkg::ST_WIDTH && cnt_reg == '0, "tenth edge did not start the width walk")
    `C39_ASSERT_NEXT(a_emit_loads, state_reg == c39etd_pkg::ST_EMIT && out_free, m_tvalid_reg && state_reg == c39etd_pkg::ST_IDLE, "pending result was not loaded")
    `C39_ASSERT_SAME(a_star_implies_sync, stars_seen_reg || last_star_reg || reversed_reg, synced_reg, "star state set without sync")

endmodule
